// ===== design/sfbp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfbp_pkg
// shared constants, error codes and piece lookup for the sfen board parser
// ----------------------------------------------------------------------------
package sfbp_pkg;

    localparam int BOARD_SIZE_DEF = 9;

    typedef logic [2:0] err_t;

    localparam err_t ERR_OK       = 3'd0;
    localparam err_t ERR_RANKS    = 3'd1;
    localparam err_t ERR_UNFILLED = 3'd2;
    localparam err_t ERR_OVERFULL = 3'd3;
    localparam err_t ERR_UNKNOWN  = 3'd4;
    localparam err_t ERR_PROMO    = 3'd5;

    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_Z  = 8'h7A;
    localparam logic [7:0] CASE_GAP = 8'h20;

    localparam logic [3:0] KIND_NONE   = 4'd0;
    localparam logic [3:0] KIND_PAWN   = 4'd1;
    localparam logic [3:0] KIND_LANCE  = 4'd2;
    localparam logic [3:0] KIND_KNIGHT = 4'd3;
    localparam logic [3:0] KIND_SILVER = 4'd4;
    localparam logic [3:0] KIND_GOLD   = 4'd5;
    localparam logic [3:0] KIND_BISHOP = 4'd6;
    localparam logic [3:0] KIND_ROOK   = 4'd7;
    localparam logic [3:0] KIND_KING   = 4'd8;
    localparam logic [3:0] PROMO_ADD   = 4'd8;

    localparam logic signed [5:0] FILES_MIN = -6'sd32;

    // uppercase letter to piece kind, zero for anything else
    function automatic logic [3:0] kind_of(input logic [7:0] up);
        logic [3:0] k;
        begin
            case (up)
                8'h50:   k = KIND_PAWN;   // P
                8'h4C:   k = KIND_LANCE;  // L
                8'h4E:   k = KIND_KNIGHT; // N
                8'h53:   k = KIND_SILVER; // S
                8'h47:   k = KIND_GOLD;   // G
                8'h42:   k = KIND_BISHOP; // B
                8'h52:   k = KIND_ROOK;   // R
                8'h4B:   k = KIND_KING;   // K
                default: k = KIND_NONE;
            endcase
            return k;
        end
    endfunction

endpackage

// ===== design/sfen_board_field_parser_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfen_board_field_parser_top
// parses the board-placement field of a shogi sfen string, one byte a beat
// ----------------------------------------------------------------------------
// usage
//   input channel: one ascii byte of the board field per beat (character),
//   with last marking the final byte of the field.
//   output channel: zero or one result beat per input beat. a result comes
//   for every placed piece (write_valid, square_file, square_rank,
//   piece_code), for the byte that first raises an error, and for the last
//   byte (done_res set). error_code carries the latched first error.
//   path: a byte is captured in the input register, and its result is
//   captured in the output register.
//   throughput: one byte per cycle while out_ready is high; the per-byte work
//   is a few narrow compares and a small counter update between the two registers.
//   stall: when the receiver holds out_ready low with a result pending, the
//   byte in the input register waits and in_ready falls, so one byte and one
//   result are held; flow resumes in the cycle out_ready rises again.
//   reset: rank 1, all files open, no pending promotion, no error. the same
//   state is restored after the result of the last byte.
// ----------------------------------------------------------------------------
module sfen_board_field_parser_top
    import sfbp_pkg::*;
#(
    parameter int BOARD_SIZE = BOARD_SIZE_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        character,
    input  logic              last,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              write_valid,
    output logic [3:0]        square_file,
    output logic [3:0]        square_rank,
    output logic signed [4:0] piece_code,
    output logic              done_res,
    output logic [2:0]        error_code
);

    localparam logic [3:0]        RankMax   = 4'(BOARD_SIZE);
    localparam logic [3:0]        RankLimit = 4'(BOARD_SIZE + 1);
    localparam logic signed [5:0] FilesRst  = 6'(BOARD_SIZE);

    // input register
    logic       in_valid_reg;
    logic [7:0] char_reg;
    logic       last_reg;

    // parser state
    logic [3:0]        rank_reg,  rank_next;
    logic signed [5:0] files_reg, files_next;
    logic              promo_reg, promo_next;
    err_t              err_reg,   err_next;

    // output register
    logic              out_valid_reg;
    logic              wr_reg;
    logic [3:0]        file_reg;
    logic [3:0]        rank_out_reg;
    logic signed [4:0] code_reg;
    logic              done_reg;
    err_t              err_out_reg;

    // byte evaluation
    logic              proc_go;
    logic              emit;
    logic              wr;
    logic [3:0]        wfile;
    logic signed [4:0] code;
    err_t              err_new;
    logic [7:0]        up;
    logic              is_lower;
    logic [3:0]        kind;
    logic [3:0]        kind_fin;
    logic [3:0]        digit;
    logic signed [6:0] files_diff;

    // a byte leaves the input register when the output slot is free or freeing
    assign proc_go  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || proc_go;

    assign is_lower   = (char_reg >= CH_LO_A) && (char_reg <= CH_LO_Z);
    assign up         = is_lower ? (char_reg - CASE_GAP) : char_reg;
    assign kind       = kind_of(up);
    assign kind_fin   = promo_reg ? (kind + PROMO_ADD) : kind;
    assign digit      = 4'(char_reg - CH_ZERO);
    assign files_diff = 7'(signed'(files_reg)) - 7'(signed'({3'b000, digit}));

    always_comb
    begin
        rank_next  = rank_reg;
        files_next = files_reg;
        promo_next = promo_reg;
        err_next   = err_reg;
        err_new    = ERR_OK;
        wr         = 1'b0;
        wfile      = 4'd0;
        code       = 5'sd0;

        if (err_reg == ERR_OK)
        begin
            if (rank_reg > RankMax)
            begin
                err_new = ERR_RANKS;
            end
            else if (char_reg == CH_SLASH)
            begin
                if (files_reg != 6'sd0)
                begin
                    err_new = (files_reg > 6'sd0) ? ERR_UNFILLED : ERR_OVERFULL;
                end
                else
                begin
                    rank_next  = rank_reg + 4'd1;
                    files_next = FilesRst;
                    promo_next = 1'b0;
                end
            end
            else if (char_reg == CH_PLUS)
            begin
                promo_next = 1'b1;
            end
            else if ((char_reg >= CH_ONE) && (char_reg <= CH_NINE))
            begin
                // saturate low so a long run of digits cannot wrap
                files_next = (files_diff < 7'(FILES_MIN)) ? FILES_MIN : files_diff[5:0];
                promo_next = 1'b0;
            end
            else if (files_reg < 6'sd1)
            begin
                err_new = ERR_OVERFULL;
            end
            else if (kind == KIND_NONE)
            begin
                err_new = ERR_UNKNOWN;
            end
            else if (promo_reg && ((kind == KIND_GOLD) || (kind == KIND_KING)))
            begin
                err_new = ERR_PROMO;
            end
            else
            begin
                wr         = 1'b1;
                wfile      = files_reg[3:0];
                code       = is_lower ? -signed'({1'b0, kind_fin}) : signed'({1'b0, kind_fin});
                files_next = files_reg - 6'sd1;
                promo_next = 1'b0;
            end

            err_next = err_new;
            // end-of-field check on the updated file count
            if (last_reg && (err_new == ERR_OK) && (files_next != 6'sd0))
            begin
                err_next = (files_next > 6'sd0) ? ERR_UNFILLED : ERR_OVERFULL;
            end
        end
    end

    assign emit = wr || (err_new != ERR_OK) || last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            char_reg <= character;
            last_reg <= last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rank_reg  <= 4'd1;
            files_reg <= FilesRst;
            promo_reg <= 1'b0;
            err_reg   <= ERR_OK;
        end
        else if (proc_go)
        begin
            if (last_reg)
            begin
                rank_reg  <= 4'd1;
                files_reg <= FilesRst;
                promo_reg <= 1'b0;
                err_reg   <= ERR_OK;
            end
            else
            begin
                rank_reg  <= rank_next;
                files_reg <= files_next;
                promo_reg <= promo_next;
                err_reg   <= err_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (proc_go)
        begin
            out_valid_reg <= emit;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc_go && emit)
        begin
            wr_reg       <= wr;
            file_reg     <= wfile;
            rank_out_reg <= wr ? rank_reg : 4'd0;
            code_reg     <= code;
            done_reg     <= last_reg;
            err_out_reg  <= err_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign write_valid = wr_reg;
    assign square_file = file_reg;
    assign square_rank = rank_out_reg;
    assign piece_code  = code_reg;
    assign done_res    = done_reg;
    assign error_code  = err_out_reg;

    // rank never runs past one beyond the board, file count never above size
    a_state_range: assert property (@(posedge clk) disable iff (!rst_n)
        (rank_reg >= 4'd1) && (rank_reg <= RankLimit) && (files_reg <= FilesRst))
        else $error("parser state out of range");

    // a placed piece lands on a real square
    a_square: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && write_valid |->
            (square_file >= 4'd1) && (square_file <= RankMax) &&
            (square_rank >= 4'd1) && (square_rank <= RankMax) && (piece_code != 5'sd0))
        else $error("write to an invalid square");

    // non-write results carry zeroed square fields
    a_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !write_valid |->
            (square_file == 4'd0) && (square_rank == 4'd0) && (piece_code == 5'sd0))
        else $error("square fields set without a write");

    // state returns to reset after the last byte
    a_field_end: assert property (@(posedge clk) disable iff (!rst_n)
        proc_go && last_reg |=>
            (rank_reg == 4'd1) && (files_reg == FilesRst) && !promo_reg && (err_reg == ERR_OK))
        else $error("state not restored after last byte");

    // a latched error holds until the field ends
    a_err_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (err_reg != ERR_OK) && !(proc_go && last_reg) |=> (err_reg == $past(err_reg)))
        else $error("latched error changed before field end");

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the sfen board field parser
// ----------------------------------------------------------------------------
// bytes of board fields are queued up front (a directed set, then random
// boards with random content, some of them corrupted, and random noise),
// offered by a falling-edge driver and checked on the rising edge against
// a behavioral parser that runs on every accepted input beat. both sides
// idle in random bursts, the receiver once holds off for a long stretch and
// the sender once waits until all predicted results have come back.
// ----------------------------------------------------------------------------
module tb_top;
    import sfbp_pkg::*;

    localparam int BOARD       = BOARD_SIZE_DEF;
    localparam int RANDOM_BYTES = 400;
    localparam int PAUSE_AT    = 230;     // sender waits for a drained block here
    localparam int HOLD_AT     = 120;     // accepted bytes before the long hold-off
    localparam int HOLD_CYCLES = 300;
    localparam int CALM_TAIL   = 60;      // last bytes run with no idling
    localparam int DRAIN_CYCLES = 20;
    localparam int LIMIT_CYCLES = 100000;
    localparam int PRINT_CAP   = 40;

    typedef struct packed {
        logic [7:0] character;
        logic       last;
        logic       drain_first;
    } board_byte_t;

    typedef struct packed {
        logic              wv;
        logic [3:0]        file;
        logic [3:0]        rank;
        logic signed [4:0] code;
        logic              done;
        err_t              err;
    } square_result_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic [7:0]        character = 8'h00;
    logic              last = 1'b0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic              write_valid;
    logic [3:0]        square_file;
    logic [3:0]        square_rank;
    logic signed [4:0] piece_code;
    logic              done_res;
    logic [2:0]        error_code;

    sfen_board_field_parser_top #(
        .BOARD_SIZE(BOARD)
    ) u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .character  (character),
        .last       (last),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .write_valid(write_valid),
        .square_file(square_file),
        .square_rank(square_rank),
        .piece_code (piece_code),
        .done_res   (done_res),
        .error_code (error_code)
    );

    // stimulus and predicted results
    board_byte_t    board_bytes_q[$];
    square_result_t parse_results_q[$];

    // behavioral parser state
    logic [3:0]        board_rank;
    logic signed [5:0] files_open;
    logic              promo_armed;
    err_t              board_error;

    // bookkeeping
    int  mismatch_count = 0;
    int  bytes_accepted = 0;
    int  total_bytes = 0;
    int  field_count = 0;
    int  results_checked = 0;
    int  writes_checked = 0;
    int  done_by_error[8];
    int  cycle_count = 0;
    logic in_taken = 1'b0;

    // idling control
    int   send_gap = 0;
    int   recv_gap = 0;
    int   hold_left = 0;
    logic hold_done = 1'b0;
    logic long_hold = 1'b0;
    wire  calm = (bytes_accepted + CALM_TAIL >= total_bytes);

    string piece_letters = "PLNSGBRK";
    string field_alphabet = "/+0123456789PLNSGBRKplnsgbrkxZ";

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // behavioral parser
    // ------------------------------------------------------------------------
    task automatic reset_board_state();
        begin
            board_rank  = 4'd1;
            files_open  = 6'(BOARD);
            promo_armed = 1'b0;
            board_error = ERR_OK;
        end
    endtask

    // slash or end of field on a rank that is not exactly full
    function automatic err_t open_rank_fault();
        begin
            return (files_open > 0) ? ERR_UNFILLED : ERR_OVERFULL;
        end
    endfunction

    function automatic logic [3:0] piece_kind(input logic [7:0] up);
        logic [3:0] k;
        begin
            k = KIND_NONE;
            if (up == "P") k = KIND_PAWN;
            if (up == "L") k = KIND_LANCE;
            if (up == "N") k = KIND_KNIGHT;
            if (up == "S") k = KIND_SILVER;
            if (up == "G") k = KIND_GOLD;
            if (up == "B") k = KIND_BISHOP;
            if (up == "R") k = KIND_ROOK;
            if (up == "K") k = KIND_KING;
            return k;
        end
    endfunction

    // one accepted byte; queues the result beat it causes, if any
    task automatic parse_board_byte(input logic [7:0] ch, input logic lst);
        square_result_t res;
        err_t           raised;
        logic [7:0]     up;
        logic [3:0]     kind;
        logic           second_player;
        int             files_next;
        begin
            res = '0;
            raised = ERR_OK;
            if (board_error == ERR_OK)
            begin
                if (board_rank > BOARD)
                begin
                    raised = ERR_RANKS;
                end
                else if (ch == CH_SLASH)
                begin
                    if (files_open != 0)
                    begin
                        raised = open_rank_fault();
                    end
                    else
                    begin
                        board_rank  = board_rank + 4'd1;
                        files_open  = 6'(BOARD);
                        promo_armed = 1'b0;
                    end
                end
                else if (ch == CH_PLUS)
                begin
                    promo_armed = 1'b1;
                end
                else if (ch >= CH_ONE && ch <= CH_NINE)
                begin
                    files_next = int'(files_open) - int'(ch - CH_ZERO);
                    if (files_next < int'(FILES_MIN))
                        files_next = int'(FILES_MIN);
                    files_open  = 6'(files_next);
                    promo_armed = 1'b0;
                end
                else if (files_open < 1)
                begin
                    raised = ERR_OVERFULL;
                end
                else
                begin
                    up = ch;
                    second_player = 1'b0;
                    if (ch >= CH_LO_A && ch <= CH_LO_Z)
                    begin
                        up = ch - CASE_GAP;
                        second_player = 1'b1;
                    end
                    kind = piece_kind(up);
                    if (kind == KIND_NONE)
                    begin
                        raised = ERR_UNKNOWN;
                    end
                    else if (promo_armed && (kind == KIND_GOLD || kind == KIND_KING))
                    begin
                        raised = ERR_PROMO;
                    end
                    else
                    begin
                        if (promo_armed)
                            kind = kind + PROMO_ADD;
                        res.wv   = 1'b1;
                        res.file = files_open[3:0];
                        res.rank = board_rank;
                        res.code = second_player ? -$signed({1'b0, kind})
                                                 : $signed({1'b0, kind});
                        files_open  = files_open - 6'sd1;
                        promo_armed = 1'b0;
                    end
                end
                if (raised != ERR_OK)
                    board_error = raised;
                // end of field check only when nothing went wrong before
                if (lst && board_error == ERR_OK && files_open != 0)
                    board_error = open_rank_fault();
            end
            if (res.wv || raised != ERR_OK || lst)
            begin
                res.done = lst;
                res.err  = board_error;
                parse_results_q.insert(parse_results_q.size(), res);
            end
            if (lst)
                reset_board_state();
        end
    endtask

    // ------------------------------------------------------------------------
    // stimulus builders
    // ------------------------------------------------------------------------
    task automatic add_byte(input logic [7:0] ch, input logic lst);
        board_byte_t b;
        begin
            b.character   = ch;
            b.last        = lst;
            b.drain_first = 1'b0;
            board_bytes_q.insert(board_bytes_q.size(), b);
            if (lst)
                field_count++;
        end
    endtask

    task automatic add_field(input string s);
        begin
            for (int i = 0; i < s.len(); i++)
                add_byte(s[i], i == s.len() - 1);
        end
    endtask

    // a board of random content, well formed unless corrupted below
    task automatic add_board();
        logic [7:0] bytes_q[$];
        logic [7:0] ch;
        int         nranks;
        int         left;
        int         run;
        int         pos;
        logic       promote;
        begin
            // now and then one rank too many, to reach the rank count error
            nranks = ($urandom_range(0, 5) == 0) ? BOARD + 1 : $urandom_range(1, BOARD);
            for (int r = 1; r <= nranks; r++)
            begin
                if (r > 1)
                    bytes_q.insert(bytes_q.size(), CH_SLASH);
                left = BOARD;
                while (left > 0)
                begin
                    if ($urandom_range(0, 2) == 0)
                    begin
                        run = $urandom_range(1, left);
                        // a digit drops a pending promotion
                        if ($urandom_range(0, 5) == 0)
                            bytes_q.insert(bytes_q.size(), CH_PLUS);
                        bytes_q.insert(bytes_q.size(), CH_ZERO + 8'(run));
                        left -= run;
                    end
                    else
                    begin
                        ch = piece_letters[$urandom_range(0, 7)];
                        if (ch == "G" || ch == "K")
                            promote = ($urandom_range(0, 19) == 0);
                        else
                            promote = ($urandom_range(0, 3) == 0);
                        if (promote)
                        begin
                            bytes_q.insert(bytes_q.size(), CH_PLUS);
                            if ($urandom_range(0, 4) == 0)
                                bytes_q.insert(bytes_q.size(), CH_PLUS);
                        end
                        if ($urandom_range(0, 1) == 1)
                            ch = ch + CASE_GAP;
                        bytes_q.insert(bytes_q.size(), ch);
                        left--;
                    end
                end
            end
            // broken boards: one byte replaced, or the tail cut off
            if ($urandom_range(0, 3) == 0)
            begin
                pos = $urandom_range(0, bytes_q.size() - 1);
                if ($urandom_range(0, 1) == 1)
                    bytes_q[pos] = 8'($urandom_range(0, 255));
                else
                    bytes_q[pos] = field_alphabet[$urandom_range(0, field_alphabet.len() - 1)];
            end
            if ($urandom_range(0, 7) == 0 && bytes_q.size() > 1)
                void'(bytes_q.pop_back());
            foreach (bytes_q[i])
                add_byte(bytes_q[i], i == bytes_q.size() - 1);
        end
    endtask

    // short field of arbitrary bytes
    task automatic add_noise();
        int         len;
        logic [7:0] ch;
        begin
            len = $urandom_range(1, 6);
            for (int i = 0; i < len; i++)
            begin
                if ($urandom_range(0, 1) == 1)
                    ch = 8'($urandom_range(0, 255));
                else
                    ch = field_alphabet[$urandom_range(0, field_alphabet.len() - 1)];
                add_byte(ch, i == len - 1);
            end
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        begin
            if (mismatch_count < PRINT_CAP)
                $display("tb_top: mismatch on %s: got %0d, want %0d (cycle %0d)",
                         what, got, want, cycle_count);
            mismatch_count++;
        end
    endtask

    // ------------------------------------------------------------------------
    // driver: offers queued bytes at the falling edge
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin : drive_bytes
        board_byte_t nxt;
        if (rst_n)
        begin
            // free to move on when idle or when the held beat was taken
            if (!in_valid || in_taken)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (board_bytes_q.size() > 0 &&
                         !(board_bytes_q[0].drain_first && parse_results_q.size() != 0))
                begin
                    nxt = board_bytes_q.pop_front();
                    in_valid  <= 1'b1;
                    character <= nxt.character;
                    last      <= nxt.last;
                    // keep offering during the long hold-off so the block backs up
                    if (!calm && !long_hold && $urandom_range(0, 5) == 0)
                        send_gap = $urandom_range(1, 14);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // receiver: out_ready bursts and one long hold-off
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin : drive_out_ready
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else if (!hold_done && bytes_accepted >= HOLD_AT)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            long_hold <= 1'b1;
            out_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
            if (hold_left == 0)
                long_hold <= 1'b0;
        end
        else if (recv_gap > 0)
        begin
            recv_gap--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
            if (!calm && $urandom_range(0, 7) == 0)
                recv_gap = $urandom_range(1, 14);
        end
    end

    // ------------------------------------------------------------------------
    // monitor: predicts on input beats, checks output beats
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : watch_beats
        square_result_t want;
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("tb_top: timeout after %0d cycles", cycle_count);
            $display("tb_top: FAIL");
            $finish;
        end
        else if (!rst_n)
        begin
            in_taken <= 1'b0;
        end
        else
        begin
            // predict first so a same-edge result would still find its entry
            if (in_valid && in_ready)
            begin
                parse_board_byte(character, last);
                bytes_accepted++;
            end
            in_taken <= in_valid && in_ready;

            if (out_valid && out_ready)
            begin
                if (parse_results_q.size() == 0)
                begin
                    report_mismatch("unexpected result beat, error_code", error_code, -1);
                end
                else
                begin
                    want = parse_results_q.pop_front();
                    if (write_valid !== want.wv)
                        report_mismatch("write_valid", write_valid, want.wv);
                    if (square_file !== want.file)
                        report_mismatch("square_file", square_file, want.file);
                    if (square_rank !== want.rank)
                        report_mismatch("square_rank", square_rank, want.rank);
                    if (piece_code !== want.code)
                        report_mismatch("piece_code", int'(piece_code), int'(want.code));
                    if (done_res !== want.done)
                        report_mismatch("done_res", done_res, want.done);
                    if (error_code !== want.err)
                        report_mismatch("error_code", error_code, want.err);
                    results_checked++;
                    if (want.wv)
                        writes_checked++;
                    if (want.done)
                        done_by_error[want.err]++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // sequence: fill the byte queue, reset, wait for the drain, report
    // ------------------------------------------------------------------------
    initial
    begin : run_test
        int start;
        logic pause_placed;
        pause_placed = 1'b0;
        foreach (done_by_error[i])
            done_by_error[i] = 0;
        reset_board_state();

        // full rank with every kind, promotions and a repeated plus
        add_field("++PLN+S+bR+rkG");
        // promoted king
        add_field("+K");
        // byte extremes: unknown byte, then a byte ignored after the error
        add_byte(8'hFF, 1'b0);
        add_byte(8'h00, 1'b1);
        // slash on an unfilled rank
        add_field("8/");
        // slash on an overfull rank
        add_field("99/");
        // piece with no room left
        add_field("9P");

        while (board_bytes_q.size() < 25 + RANDOM_BYTES)
        begin
            start = board_bytes_q.size();
            if ($urandom_range(0, 9) < 7)
                add_board();
            else
                add_noise();
            // one field waits until every predicted beat is back
            if (!pause_placed && start >= PAUSE_AT)
            begin
                board_bytes_q[start].drain_first = 1'b1;
                pause_placed = 1'b1;
            end
        end
        total_bytes = board_bytes_q.size();

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (board_bytes_q.size() != 0 || in_valid || parse_results_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (parse_results_q.size() != 0)
            report_mismatch("results still expected", 0, parse_results_q.size());

        $display("tb_top: %0d bytes in %0d fields, %0d result beats, %0d square writes",
                 bytes_accepted, field_count, results_checked, writes_checked);
        $display("tb_top: field ends ok %0d ranks %0d unfilled %0d overfull %0d %s %0d %s %0d",
                 done_by_error[ERR_OK], done_by_error[ERR_RANKS],
                 done_by_error[ERR_UNFILLED], done_by_error[ERR_OVERFULL],
                 "unknown", done_by_error[ERR_UNKNOWN],
                 "promotion", done_by_error[ERR_PROMO]);
        if (mismatch_count == 0)
        begin
            $display("tb_top: PASS");
        end
        else
        begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule
